@@ rtl/ldl_pkg.sv @@
// Package for the Lambert diffuse lighting core: item types, register codes,
// light table sizes and fixed-point constants. Used by every other file under rtl.
package ldl_pkg;

  localparam int MAX_LIGHTS = 8;
  localparam int LIDX_W     = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
  localparam int CNT_W      = $clog2(MAX_LIGHTS + 1);

  // Command codes of the input item.
  localparam logic [1:0] CMD_SHADE = 2'd0;
  localparam logic [1:0] CMD_DIR   = 2'd1;
  localparam logic [1:0] CMD_POINT = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_AMB_RED   = 2'd0;
  localparam logic [1:0] REG_AMB_GREEN = 2'd1;
  localparam logic [1:0] REG_AMB_BLUE  = 2'd2;
  localparam logic [1:0] REG_AMB_LEVEL = 2'd3;

  // Fixed-point constants.
  localparam logic [16:0] ONE_Q16      = 17'd65536;
  localparam logic [13:0] ATT_LIN_Q20  = 14'd10486;
  localparam logic [10:0] ATT_QUAD_Q20 = 11'd1049;

  // Reset light: the sun direction (-128,-256,-77) already normalized to Q2.14.
  localparam logic signed [19:0] SUN_UX = -20'sd7076;
  localparam logic signed [19:0] SUN_UY = -20'sd14151;
  localparam logic signed [19:0] SUN_UZ = -20'sd4256;
  localparam logic [8:0]         SUN_R  = 9'd256;
  localparam logic [8:0]         SUN_G  = 9'd243;
  localparam logic [8:0]         SUN_B  = 9'd205;
  localparam logic [9:0]         SUN_LVL = 10'd205;

  // Iterative unit sizes.
  localparam int ROOT_W = 29;   // root of a 58-bit radicand
  localparam int QUO_W  = 17;   // quotients never exceed 65536
  localparam int NUM_W  = 43;
  localparam int DEN_W  = 35;

  typedef enum logic [1:0] {
    K_SHADE,
    K_DIR,
    K_POINT,
    K_CLEAR
  } kind_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [19:0] point_x;
    logic signed [19:0] point_y;
    logic signed [19:0] point_z;
    logic signed [19:0] normal_x;
    logic signed [19:0] normal_y;
    logic signed [19:0] normal_z;
    logic [8:0]         red;
    logic [8:0]         green;
    logic [8:0]         blue;
    logic [9:0]         intensity;
  } in_item_t;

  typedef struct packed {
    logic [8:0] out_red;
    logic [8:0] out_green;
    logic [8:0] out_blue;
  } out_item_t;

  typedef struct packed {
    kind_e    kind;
    in_item_t data;
  } q_item_t;

  typedef struct packed {
    logic [8:0] amb_red;
    logic [8:0] amb_green;
    logic [8:0] amb_blue;
    logic [9:0] amb_level;
  } amb_cfg_t;

  typedef struct packed {
    logic              start;
    logic [2*ROOT_W-1:0] rad;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

@@ rtl/ldl_front.sv @@
// Front end of the lighting core: accepts input items, classifies the command
// and holds them in a two-entry queue for the back end. Uses ldl_pkg.
module ldl_front
  import ldl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  output q_item_t  q_item_o,
  input  logic     q_pop_i
);

  q_item_t    qmem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  kind_e      kind;

  always_comb begin
    case (in_item_i.cmd)
      CMD_SHADE: kind = K_SHADE;
      CMD_DIR:   kind = K_DIR;
      CMD_POINT: kind = K_POINT;
      CMD_CLEAR: kind = K_CLEAR;
      default:   kind = K_SHADE;
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = qmem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        qmem_q[wr_ptr_q] <= '{kind: kind, data: in_item_i};
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (q_pop_i && q_valid_o) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop_i && q_valid_o};
    end
  end

endmodule

@@ rtl/ldl_sqrt.sv @@
// Bit-serial integer square root for the lighting core, one root bit per
// cycle. Uses ldl_pkg for widths and request types.
module ldl_sqrt
  import ldl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  localparam int CW = $clog2(ROOT_W + 1);

  logic [2*ROOT_W-1:0] x_q;
  logic [ROOT_W+2:0]   rem_q;
  logic [ROOT_W-1:0]   root_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q, done_q;
  logic [ROOT_W+2:0]   rem_sh, trial;

  assign rem_sh = {rem_q[ROOT_W:0], x_q[2*ROOT_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        x_q    <= req_i.rad;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= CW'(ROOT_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (rem_sh >= trial) begin
          rem_q  <= rem_sh - trial;
          root_q <= {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= rem_sh;
          root_q <= {root_q[ROOT_W-2:0], 1'b0};
        end
        x_q   <= {x_q[2*ROOT_W-3:0], 2'b00};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, root: root_q};

endmodule

@@ rtl/ldl_div.sv @@
// Restoring divider for the lighting core, one quotient bit per cycle.
// Callers guarantee that the quotient fits QUO_W bits. Uses ldl_pkg.
module ldl_div
  import ldl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CW = $clog2(QUO_W + 1);
  localparam int SW = DEN_W + QUO_W - 1;

  logic [NUM_W-1:0] rem_q;
  logic [SW-1:0]    dsh_q;
  logic [QUO_W-1:0] quo_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;
  logic             fits;

  assign fits = {{(SW-NUM_W){1'b0}}, rem_q} >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        rem_q  <= req_i.num;
        dsh_q  <= {req_i.den, {(QUO_W-1){1'b0}}};
        quo_q  <= '0;
        cnt_q  <= CW'(QUO_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        // When the shifted divisor fits, it is below 2^NUM_W, so its low bits are all of it.
        if (fits) begin
          rem_q <= rem_q - dsh_q[NUM_W-1:0];
        end
        quo_q <= {quo_q[QUO_W-2:0], fits};
        dsh_q <= {1'b0, dsh_q[SW-1:1]};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o = '{done: done_q, quo: quo_q};

endmodule

@@ rtl/ldl_back.sv @@
// Back end of the lighting core: light table, shading sequencer with one
// shared multiplier, and the output register. Uses ldl_pkg, drives ldl_sqrt
// and ldl_div through request structs.
module ldl_back
  import ldl_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  amb_cfg_t  cfg_i,
  input  logic      q_valid_i,
  input  q_item_t   q_item_i,
  output logic      q_pop_o,
  output sqrt_req_t sqrt_req_o,
  input  sqrt_rsp_t sqrt_rsp_i,
  output div_req_t  div_req_o,
  input  div_rsp_t  div_rsp_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_AMB_A, S_AMB_B, S_NSQ, S_NRT, S_NRT_W, S_NDV, S_NDV_W, S_NRET,
    S_LFETCH, S_ATT_A, S_ATT_B, S_ATT_C, S_ATT_W, S_DOT, S_COS, S_CON,
    S_CH_A, S_CH_B, S_DONE
  } state_e;

  typedef enum logic [1:0] {
    R_ADD,
    R_NORMAL,
    R_POINT
  } ret_e;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LIGHTS);

  state_e state_q;
  ret_e   ret_q;

  // Light table.
  logic               lt_point_q [MAX_LIGHTS];
  logic signed [19:0] lt_vec_q   [MAX_LIGHTS][3];
  logic [8:0]         lt_col_q   [MAX_LIGHTS][3];
  logic [9:0]         lt_lvl_q   [MAX_LIGHTS];
  logic [CNT_W-1:0]   count_q;

  // Working registers.
  in_item_t           it_q;
  logic [1:0]         ch_q;
  logic [CNT_W-1:0]   li_q;
  logic signed [20:0] nv_q [3];
  logic signed [15:0] u_q [3];
  logic signed [15:0] nu_q [3];
  logic signed [15:0] dir_q [3];
  logic [41:0]        s_q;
  logic [ROOT_W-1:0]  lenq_q;
  logic [41:0]        sq_q;
  logic [DEN_W-1:0]   den_q;
  logic [QUO_W-1:0]   att_q;
  logic signed [31:0] dot_q;
  logic [25:0]        t_q;
  logic [26:0]        contrib_q;
  logic [48:0]        acc_q [3];
  logic               out_valid_q;
  out_item_t          out_q;

  // Combinational helpers.
  logic signed [19:0] p_vec [3];
  logic signed [19:0] n_vec [3];
  logic [8:0]         mat [3];
  logic [8:0]         amb [3];
  logic [LIDX_W-1:0]  li_idx, wr_idx;
  logic               cur_point;
  logic [20:0]        nv_mag;
  logic signed [31:0] dotn;
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [42:0]        lin_prod;
  logic [52:0]        quad_prod;
  logic [DEN_W-1:0]   den_d;
  logic [18:0]        sat_in [3];
  logic [8:0]         sat_out [3];
  logic               table_free;

  always_comb begin
    p_vec[0] = it_q.point_x;
    p_vec[1] = it_q.point_y;
    p_vec[2] = it_q.point_z;
    n_vec[0] = it_q.normal_x;
    n_vec[1] = it_q.normal_y;
    n_vec[2] = it_q.normal_z;
    mat[0]   = it_q.red;
    mat[1]   = it_q.green;
    mat[2]   = it_q.blue;
    amb[0]   = cfg_i.amb_red;
    amb[1]   = cfg_i.amb_green;
    amb[2]   = cfg_i.amb_blue;
    li_idx    = li_q[LIDX_W-1:0];
    wr_idx    = count_q[LIDX_W-1:0];
    cur_point = lt_point_q[li_idx];
    table_free = (count_q < MAX_CNT);
    nv_mag = nv_q[ch_q][20] ? 21'(-nv_q[ch_q]) : 21'(nv_q[ch_q]);
    // Only point-light vectors point away from the surface; directional ones are negated.
    dotn = cur_point ? dot_q : -dot_q;

    case (state_q)
      S_AMB_A: begin
        mul_a = {23'b0, mat[ch_q]};
        mul_b = {23'b0, amb[ch_q]};
      end
      S_AMB_B: begin
        mul_a = {6'b0, t_q};
        mul_b = {22'b0, cfg_i.amb_level};
      end
      S_NSQ: begin
        mul_a = {{11{nv_q[ch_q][20]}}, nv_q[ch_q]};
        mul_b = {{11{nv_q[ch_q][20]}}, nv_q[ch_q]};
      end
      S_ATT_A: begin
        mul_a = {3'b0, lenq_q};
        mul_b = {3'b0, lenq_q};
      end
      S_DOT: begin
        mul_a = {{16{nu_q[ch_q][15]}}, nu_q[ch_q]};
        mul_b = {{16{dir_q[ch_q][15]}}, dir_q[ch_q]};
      end
      S_COS: begin
        mul_a = {14'b0, dotn[31:14]};
        mul_b = {22'b0, lt_lvl_q[li_idx]};
      end
      S_CON: begin
        mul_a = {6'b0, t_q};
        mul_b = {15'b0, att_q};
      end
      S_CH_A: begin
        mul_a = {23'b0, mat[ch_q]};
        mul_b = {23'b0, lt_col_q[li_idx][ch_q]};
      end
      S_CH_B: begin
        mul_a = {6'b0, t_q};
        mul_b = {5'b0, contrib_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod = mul_a * mul_b;

    lin_prod  = {14'b0, lenq_q} * {29'b0, ATT_LIN_Q20};
    quad_prod = {11'b0, sq_q} * {42'b0, ATT_QUAD_Q20};
    den_d = {18'b0, ONE_Q16} + {12'b0, lin_prod[42:20]} + {2'b0, quad_prod[52:20]};

    sqrt_req_o.start = (state_q == S_NRT);
    sqrt_req_o.rad   = {s_q, 16'b0};

    div_req_o.start = ((state_q == S_NDV) && (lenq_q != '0)) || (state_q == S_ATT_C);
    if (state_q == S_ATT_C) begin
      div_req_o.num = NUM_W'({1'b1, 32'b0}) + NUM_W'(den_q[DEN_W-1:1]);
      div_req_o.den = den_q;
    end else begin
      div_req_o.num = {nv_mag, 22'b0} + NUM_W'(lenq_q[ROOT_W-1:1]);
      div_req_o.den = DEN_W'(lenq_q);
    end

    for (int c = 0; c < 3; c++) begin
      sat_in[c]  = acc_q[c][48:30];
      sat_out[c] = (sat_in[c] > 19'd256) ? 9'd256 : sat_in[c][8:0];
    end
  end

  assign q_pop_o = (state_q == S_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= R_ADD;
      out_valid_q <= 1'b0;
      count_q     <= CNT_W'(1);
      ch_q        <= '0;
      li_q        <= '0;
      for (int i = 1; i < MAX_LIGHTS; i++) begin
        lt_point_q[i] <= 1'b0;
        lt_lvl_q[i]   <= '0;
        for (int c = 0; c < 3; c++) begin
          lt_vec_q[i][c] <= '0;
          lt_col_q[i][c] <= '0;
        end
      end
      lt_point_q[0]  <= 1'b0;
      lt_vec_q[0][0] <= SUN_UX;
      lt_vec_q[0][1] <= SUN_UY;
      lt_vec_q[0][2] <= SUN_UZ;
      lt_col_q[0][0] <= SUN_R;
      lt_col_q[0][1] <= SUN_G;
      lt_col_q[0][2] <= SUN_B;
      lt_lvl_q[0]    <= SUN_LVL;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            it_q <= q_item_i.data;
            ch_q <= '0;
            s_q  <= '0;
            case (q_item_i.kind)
              K_CLEAR: begin
                count_q <= '0;
              end
              K_POINT: begin
                if (table_free) begin
                  lt_point_q[wr_idx]  <= 1'b1;
                  lt_vec_q[wr_idx][0] <= q_item_i.data.point_x;
                  lt_vec_q[wr_idx][1] <= q_item_i.data.point_y;
                  lt_vec_q[wr_idx][2] <= q_item_i.data.point_z;
                  lt_col_q[wr_idx][0] <= q_item_i.data.red;
                  lt_col_q[wr_idx][1] <= q_item_i.data.green;
                  lt_col_q[wr_idx][2] <= q_item_i.data.blue;
                  lt_lvl_q[wr_idx]    <= q_item_i.data.intensity;
                  count_q <= count_q + 1'b1;
                end
              end
              K_DIR: begin
                if (table_free) begin
                  nv_q[0] <= {q_item_i.data.point_x[19], q_item_i.data.point_x};
                  nv_q[1] <= {q_item_i.data.point_y[19], q_item_i.data.point_y};
                  nv_q[2] <= {q_item_i.data.point_z[19], q_item_i.data.point_z};
                  ret_q   <= R_ADD;
                  state_q <= S_NSQ;
                end
              end
              default: begin
                state_q <= S_AMB_A;
              end
            endcase
          end
        end
        S_AMB_A: begin
          t_q     <= prod[25:0];
          state_q <= S_AMB_B;
        end
        S_AMB_B: begin
          acc_q[ch_q] <= {prod[34:0], 14'b0};
          if (ch_q == 2'd2) begin
            for (int c = 0; c < 3; c++) begin
              nv_q[c] <= {n_vec[c][19], n_vec[c]};
            end
            s_q     <= '0;
            ch_q    <= '0;
            ret_q   <= R_NORMAL;
            state_q <= S_NSQ;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_AMB_A;
          end
        end
        S_NSQ: begin
          s_q <= s_q + prod[41:0];
          if (ch_q == 2'd2) begin
            state_q <= S_NRT;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
        S_NRT: begin
          state_q <= S_NRT_W;
        end
        S_NRT_W: begin
          if (sqrt_rsp_i.done) begin
            lenq_q  <= sqrt_rsp_i.root;
            ch_q    <= '0;
            state_q <= S_NDV;
          end
        end
        S_NDV: begin
          if (lenq_q == '0) begin
            u_q[ch_q] <= '0;
            if (ch_q == 2'd2) begin
              state_q <= S_NRET;
            end else begin
              ch_q <= ch_q + 1'b1;
            end
          end else begin
            state_q <= S_NDV_W;
          end
        end
        S_NDV_W: begin
          if (div_rsp_i.done) begin
            u_q[ch_q] <= nv_q[ch_q][20] ? -div_rsp_i.quo[15:0] : div_rsp_i.quo[15:0];
            if (ch_q == 2'd2) begin
              state_q <= S_NRET;
            end else begin
              ch_q    <= ch_q + 1'b1;
              state_q <= S_NDV;
            end
          end
        end
        S_NRET: begin
          case (ret_q)
            R_ADD: begin
              lt_point_q[wr_idx] <= 1'b0;
              for (int c = 0; c < 3; c++) begin
                lt_vec_q[wr_idx][c] <= {{4{u_q[c][15]}}, u_q[c]};
              end
              lt_col_q[wr_idx][0] <= it_q.red;
              lt_col_q[wr_idx][1] <= it_q.green;
              lt_col_q[wr_idx][2] <= it_q.blue;
              lt_lvl_q[wr_idx]    <= it_q.intensity;
              count_q <= count_q + 1'b1;
              state_q <= S_IDLE;
            end
            R_NORMAL: begin
              for (int c = 0; c < 3; c++) begin
                nu_q[c] <= u_q[c];
              end
              li_q    <= '0;
              state_q <= S_LFETCH;
            end
            R_POINT: begin
              for (int c = 0; c < 3; c++) begin
                dir_q[c] <= u_q[c];
              end
              dot_q <= '0;
              ch_q  <= '0;
              if (lenq_q == '0) begin
                att_q   <= ONE_Q16;
                state_q <= S_DOT;
              end else begin
                state_q <= S_ATT_A;
              end
            end
            default: begin
              state_q <= S_IDLE;
            end
          endcase
        end
        S_LFETCH: begin
          ch_q <= '0;
          if (li_q >= count_q) begin
            state_q <= S_DONE;
          end else if (cur_point) begin
            for (int c = 0; c < 3; c++) begin
              nv_q[c] <= {lt_vec_q[li_idx][c][19], lt_vec_q[li_idx][c]}
                       - {p_vec[c][19], p_vec[c]};
            end
            s_q     <= '0;
            ret_q   <= R_POINT;
            state_q <= S_NSQ;
          end else begin
            for (int c = 0; c < 3; c++) begin
              dir_q[c] <= lt_vec_q[li_idx][c][15:0];
            end
            att_q   <= ONE_Q16;
            dot_q   <= '0;
            state_q <= S_DOT;
          end
        end
        S_ATT_A: begin
          sq_q    <= prod[57:16];
          state_q <= S_ATT_B;
        end
        S_ATT_B: begin
          den_q   <= den_d;
          state_q <= S_ATT_C;
        end
        S_ATT_C: begin
          state_q <= S_ATT_W;
        end
        S_ATT_W: begin
          if (div_rsp_i.done) begin
            att_q   <= div_rsp_i.quo;
            dot_q   <= '0;
            ch_q    <= '0;
            state_q <= S_DOT;
          end
        end
        S_DOT: begin
          dot_q <= dot_q + prod[31:0];
          if (ch_q == 2'd2) begin
            state_q <= S_COS;
          end else begin
            ch_q <= ch_q + 1'b1;
          end
        end
        S_COS: begin
          if (dotn > 32'sd0) begin
            t_q     <= prod[25:0];
            state_q <= S_CON;
          end else begin
            li_q    <= li_q + 1'b1;
            state_q <= S_LFETCH;
          end
        end
        S_CON: begin
          contrib_q <= prod[42:16];
          ch_q      <= '0;
          state_q   <= S_CH_A;
        end
        S_CH_A: begin
          t_q     <= prod[25:0];
          state_q <= S_CH_B;
        end
        S_CH_B: begin
          acc_q[ch_q] <= acc_q[ch_q] + prod[48:0];
          if (ch_q == 2'd2) begin
            li_q    <= li_q + 1'b1;
            state_q <= S_LFETCH;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_CH_A;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_q.out_red   <= sat_out[0];
            out_q.out_green <= sat_out[1];
            out_q.out_blue  <= sat_out[2];
            out_valid_q     <= 1'b1;
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MAX_CNT)
    else $error("light count exceeds the table size");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && q_valid_i && q_item_i.kind == K_CLEAR) |=> (count_q == '0))
    else $error("clear command did not empty the light table");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result produced outside the finishing step");

endmodule

@@ rtl/lambert_diffuse_lighting_core.sv @@
// Top level of the Lambert diffuse lighting core: configuration registers,
// front queue, shading back end and its root and divide units. Uses ldl_pkg.
//
// Shade items produce one lit color; append and clear commands update the
// light table and produce nothing. Items are queued two deep and run one at a
// time in the back end. An append of a point light or a clear is done in the
// idle state; an append of a directional light first normalizes its vector. A
// shade item works out the ambient term, the normal and the result, then
// the products of each lit light; a light that faces away skips them. Output
// stalls add to its time. The time is set by the bit-serial square root and
// the divider, which a normal or a directional light uses once and up to three
// times and a point light once and up to four times, and by the single shared
// multiplier that the per-channel products pass through.
module lambert_diffuse_lighting_core
  import ldl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  amb_cfg_t  cfg_q;
  logic      q_valid, q_pop;
  q_item_t   q_item;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amb_red   <= 9'd51;
      cfg_q.amb_green <= 9'd51;
      cfg_q.amb_blue  <= 9'd77;
      cfg_q.amb_level <= 10'd77;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_AMB_RED:   cfg_q.amb_red   <= pwdata[8:0];
        REG_AMB_GREEN: cfg_q.amb_green <= pwdata[8:0];
        REG_AMB_BLUE:  cfg_q.amb_blue  <= pwdata[8:0];
        REG_AMB_LEVEL: cfg_q.amb_level <= pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_AMB_RED:   prdata = {23'b0, cfg_q.amb_red};
      REG_AMB_GREEN: prdata = {23'b0, cfg_q.amb_green};
      REG_AMB_BLUE:  prdata = {23'b0, cfg_q.amb_blue};
      REG_AMB_LEVEL: prdata = {22'b0, cfg_q.amb_level};
      default:       prdata = '0;
    endcase
  end

  ldl_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  ldl_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .rsp_o  (sqrt_rsp)
  );

  ldl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ldl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .sqrt_req_o  (sqrt_req),
    .sqrt_rsp_i  (sqrt_rsp),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
